@@ hdl/swrl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sliding window rate limiter.
// No dependencies.

package swrl_pkg;

    localparam int TS_W           = 32;
    localparam int CNT_W          = 16;
    localparam int LIM_W          = 16;
    localparam int WIN_W          = 7;
    localparam int DROP_W         = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int OUT_TDATA_W    = 40;
    localparam int RING_DEPTH_DEF = 64;

    localparam logic [LIM_W-1:0] SECOND_LIMIT_RST = 16'd3;
    localparam logic [LIM_W-1:0] SHORT_LIMIT_RST  = 16'd20;
    localparam logic [LIM_W-1:0] LONG_LIMIT_RST   = 16'd60;
    localparam logic [WIN_W-1:0] SHORT_WINDOW_RST = 7'd10;
    localparam logic [WIN_W-1:0] LONG_WINDOW_RST  = 7'd60;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SECOND_LIMIT = 3'd0,
        CFG_SHORT_LIMIT  = 3'd1,
        CFG_LONG_LIMIT   = 3'd2,
        CFG_SHORT_WINDOW = 3'd3,
        CFG_LONG_WINDOW  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_WALK,
        S_READ,
        S_UPD
    } t_state;

endpackage

@@ hdl/swrl_urem.sv @@
`timescale 1ns / 1ps
// Ring index advance: sum of two indexes below a constant depth, wrapped by one subtract.
// Depends on swrl_pkg.

module swrl_urem #(
    parameter int DIVISOR = swrl_pkg::RING_DEPTH_DEF
) (
    input  logic [$clog2(DIVISOR)-1:0] i_base,
    input  logic [$clog2(DIVISOR)-1:0] i_step,
    output logic [$clog2(DIVISOR)-1:0] o_rem
);

    localparam int RW = $clog2(DIVISOR);
    localparam logic [RW:0] DIV_C = (RW + 1)'(DIVISOR);

    logic [RW:0] wide_sum;

    always_comb begin
        wide_sum = {1'b0, i_base} + {1'b0, i_step};
        if (wide_sum >= DIV_C) begin
            o_rem = RW'(wide_sum - DIV_C);
        end else begin
            o_rem = wide_sum[RW-1:0];
        end
    end

endmodule

@@ hdl/sliding_window_rate_limiter_top.sv @@
`timescale 1ns / 1ps
// Sliding window rate limiter: per-second count ring in one RAM, running window sums.
// Depends on swrl_pkg and swrl_urem.
//
// channel  | direction | handshake                    | payload
// ---------+-----------+------------------------------+----------------------------------
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata[31:0] timestamp
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata dropped, out_of_order, total
// cfg      | in        | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// Same-second request: accept, plan, bucket read, update, in that order, set by the ring RAM
// read-modify-write. A new second adds a walk of max(gap, window) ring entries before the read.
// First request after reset, or a gap of RING_DEPTH or more: a pass over all RING_DEPTH entries clears
// the ring and restarts the window sums; no clearing pass at reset.
// A changed window length forces one window walk on the next request that is not out of order.
// The result sits in an output register; the update stalls while it is not taken.

module sliding_window_rate_limiter_top #(
    parameter int RING_DEPTH = swrl_pkg::RING_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tdata: [31:0] timestamp
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [swrl_pkg::TS_W-1:0]          s_axis_tdata,
    // tdata: [0] dropped, [1] out_of_order, [33:2] drop_total, [39:34] zero
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [swrl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [swrl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [swrl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int CW     = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = swrl_pkg::CNT_W + CW;
    localparam int CMP_W  = (CW > swrl_pkg::WIN_W) ? CW : swrl_pkg::WIN_W;
    localparam int TS_W   = swrl_pkg::TS_W;
    localparam int PAD_W  = swrl_pkg::OUT_TDATA_W - swrl_pkg::DROP_W - 2;

    localparam logic [CW-1:0]    DEPTH_C   = CW'(RING_DEPTH);
    localparam logic [AW:0]      DEPTH_A   = (AW + 1)'(RING_DEPTH);
    localparam logic [AW-1:0]    LAST_POS  = AW'(RING_DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(RING_DEPTH);
    localparam logic [TS_W-1:0]  DEPTH_TS  = TS_W'(RING_DEPTH);

    // configuration
    logic [swrl_pkg::LIM_W-1:0] r_second_limit;
    logic [swrl_pkg::LIM_W-1:0] r_short_limit;
    logic [swrl_pkg::LIM_W-1:0] r_long_limit;
    logic [swrl_pkg::WIN_W-1:0] r_short_window;
    logic [swrl_pkg::WIN_W-1:0] r_long_window;
    logic                       r_dirty;

    // control and datapath state
    swrl_pkg::t_state r_state, n_state;
    logic [TS_W-1:0]  r_ts, n_ts;
    logic [TS_W-1:0]  r_cur_second, n_cur_second;
    logic             r_time_seen, n_time_seen;
    logic [AW-1:0]    r_cur_idx, n_cur_idx;
    logic [AW-1:0]    r_pos, n_pos;
    logic [CW-1:0]    r_k, n_k;
    logic [CW-1:0]    r_gap, n_gap;
    logic [CW-1:0]    r_seff, n_seff;
    logic [CW-1:0]    r_leff, n_leff;
    logic [CW-1:0]    r_walk_n, n_walk_n;
    logic             r_oo, n_oo;
    logic             r_acc_s, n_acc_s;
    logic             r_acc_l, n_acc_l;

    logic [SUM_W-1:0]            r_short_sum;
    logic [SUM_W-1:0]            r_long_sum;
    logic [swrl_pkg::DROP_W-1:0] r_drop_total;
    logic [swrl_pkg::DROP_W-1:0] drop_next;
    logic                        r_out_valid;
    logic [swrl_pkg::OUT_TDATA_W-1:0] r_out_data;

    // ring memory
    logic [swrl_pkg::CNT_W-1:0] r_ring [RING_DEPTH];
    logic [swrl_pkg::CNT_W-1:0] r_rdata;
    logic                       ring_wr;
    logic                       ring_rd;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic [swrl_pkg::CNT_W-1:0] wr_data;

    // plan and update terms
    logic [CMP_W-1:0] sw_ext, lw_ext;
    logic [CW-1:0]    swc, lwc, seff, leff, wmax, gap, walk_n;
    logic [TS_W-1:0]  diff;
    logic             clear_all, backward;
    logic [AW-1:0]    idx_next;
    logic             drop, bucket_inc, commit, sum_clr, dirty_clr;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second_limit <= swrl_pkg::SECOND_LIMIT_RST;
            r_short_limit  <= swrl_pkg::SHORT_LIMIT_RST;
            r_long_limit   <= swrl_pkg::LONG_LIMIT_RST;
            r_short_window <= swrl_pkg::SHORT_WINDOW_RST;
            r_long_window  <= swrl_pkg::LONG_WINDOW_RST;
            r_dirty        <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (swrl_pkg::t_cfg_idx'(i_cfg_index))
                swrl_pkg::CFG_SECOND_LIMIT: r_second_limit <= i_cfg_data;
                swrl_pkg::CFG_SHORT_LIMIT:  r_short_limit  <= i_cfg_data;
                swrl_pkg::CFG_LONG_LIMIT:   r_long_limit   <= i_cfg_data;
                swrl_pkg::CFG_SHORT_WINDOW: begin
                    r_short_window <= i_cfg_data[swrl_pkg::WIN_W-1:0];
                    r_dirty        <= 1'b1;
                end
                swrl_pkg::CFG_LONG_WINDOW: begin
                    r_long_window <= i_cfg_data[swrl_pkg::WIN_W-1:0];
                    r_dirty       <= 1'b1;
                end
                default: ;
            endcase
        end else if (dirty_clr) begin
            r_dirty <= 1'b0;
        end
    end

    swrl_urem #(
        .DIVISOR (RING_DEPTH)
    ) u_urem (
        .i_base (r_cur_idx),
        .i_step (diff[AW-1:0]),
        .o_rem  (idx_next)
    );

    always_comb begin
        sw_ext = CMP_W'(r_short_window);
        lw_ext = CMP_W'(r_long_window);
        if (r_short_window == '0) begin
            swc = CW'(1);
        end else if (sw_ext > DEPTH_CMP) begin
            swc = DEPTH_C;
        end else begin
            swc = CW'(sw_ext);
        end
        if (r_long_window == '0) begin
            lwc = CW'(1);
        end else if (lw_ext > DEPTH_CMP) begin
            lwc = DEPTH_C;
        end else begin
            lwc = CW'(lw_ext);
        end
        // clip the windows at second zero
        seff = (r_ts < TS_W'(swc)) ? CW'(r_ts) + CW'(1) : swc;
        leff = (r_ts < TS_W'(lwc)) ? CW'(r_ts) + CW'(1) : lwc;
        wmax = (seff > leff) ? seff : leff;

        backward  = r_time_seen && (r_ts < r_cur_second);
        diff      = r_ts - r_cur_second;
        clear_all = !r_time_seen || (diff >= DEPTH_TS);
        gap       = clear_all ? DEPTH_C : CW'(diff);
        walk_n    = (gap > wmax) ? gap : wmax;

        bucket_inc = (r_rdata != '1);
        drop = !r_oo && ((r_rdata >= r_second_limit) ||
                         (r_short_sum >= SUM_W'(r_short_limit)) ||
                         (r_long_sum >= SUM_W'(r_long_limit)));
        drop_next = (drop && (r_drop_total != '1)) ? r_drop_total + swrl_pkg::DROP_W'(1)
                                                   : r_drop_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swrl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ts         = r_ts;
        n_cur_second = r_cur_second;
        n_time_seen  = r_time_seen;
        n_cur_idx    = r_cur_idx;
        n_pos        = r_pos;
        n_k          = r_k;
        n_gap        = r_gap;
        n_seff       = r_seff;
        n_leff       = r_leff;
        n_walk_n     = r_walk_n;
        n_oo         = r_oo;
        n_acc_s      = 1'b0;
        n_acc_l      = 1'b0;
        s_axis_tready = 1'b0;
        ring_wr      = 1'b0;
        ring_rd      = 1'b0;
        wr_addr      = r_pos;
        rd_addr      = r_pos;
        wr_data      = '0;
        sum_clr      = 1'b0;
        dirty_clr    = 1'b0;
        commit       = 1'b0;
        unique case (r_state)
            swrl_pkg::S_IDLE: begin
                s_axis_tready = i_rst_n;
                if (s_axis_tvalid) begin
                    n_ts    = s_axis_tdata;
                    n_state = swrl_pkg::S_PLAN;
                end
            end
            swrl_pkg::S_PLAN: begin
                n_oo     = backward;
                n_gap    = gap;
                n_seff   = seff;
                n_leff   = leff;
                n_walk_n = walk_n;
                n_k      = '0;
                if (backward) begin
                    n_state = swrl_pkg::S_UPD;
                end else begin
                    n_cur_second = r_ts;
                    n_time_seen  = 1'b1;
                    dirty_clr    = 1'b1;
                    if (clear_all) begin
                        sum_clr = 1'b1;
                        n_pos   = r_cur_idx;
                        n_state = swrl_pkg::S_WALK;
                    end else begin
                        n_cur_idx = idx_next;
                        n_pos     = idx_next;
                        if ((gap != '0) || r_dirty) begin
                            sum_clr = 1'b1;
                            n_state = swrl_pkg::S_WALK;
                        end else begin
                            n_state = swrl_pkg::S_READ;
                        end
                    end
                end
            end
            swrl_pkg::S_WALK: begin
                // clear the new seconds, sum the older ones still in a window
                if (r_k < r_gap) begin
                    ring_wr = 1'b1;
                end else begin
                    n_acc_s = (r_k < r_seff);
                    n_acc_l = (r_k < r_leff);
                    ring_rd = n_acc_s || n_acc_l;
                end
                n_k   = r_k + CW'(1);
                n_pos = (r_pos == '0) ? LAST_POS : r_pos - AW'(1);
                if (r_k == r_walk_n - CW'(1)) begin
                    n_state = swrl_pkg::S_READ;
                end
            end
            swrl_pkg::S_READ: begin
                ring_rd = 1'b1;
                rd_addr = r_cur_idx;
                n_state = swrl_pkg::S_UPD;
            end
            swrl_pkg::S_UPD: begin
                if (!r_out_valid || m_axis_tready) begin
                    commit  = 1'b1;
                    ring_wr = !r_oo && bucket_inc;
                    wr_addr = r_cur_idx;
                    wr_data = r_rdata + swrl_pkg::CNT_W'(1);
                    n_state = swrl_pkg::S_IDLE;
                end
            end
            default: n_state = swrl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_second <= '0;
            r_time_seen  <= 1'b0;
            r_cur_idx    <= '0;
            r_k          <= '0;
            r_acc_s      <= 1'b0;
            r_acc_l      <= 1'b0;
            r_oo         <= 1'b0;
        end else begin
            r_cur_second <= n_cur_second;
            r_time_seen  <= n_time_seen;
            r_cur_idx    <= n_cur_idx;
            r_k          <= n_k;
            r_acc_s      <= n_acc_s;
            r_acc_l      <= n_acc_l;
            r_oo         <= n_oo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ts     <= n_ts;
        r_pos    <= n_pos;
        r_gap    <= n_gap;
        r_seff   <= n_seff;
        r_leff   <= n_leff;
        r_walk_n <= n_walk_n;
    end

    always_ff @(posedge i_clk) begin
        if (ring_wr) begin
            r_ring[wr_addr] <= wr_data;
        end
        if (ring_rd) begin
            r_rdata <= r_ring[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_sum <= '0;
            r_long_sum  <= '0;
        end else if (sum_clr) begin
            r_short_sum <= '0;
            r_long_sum  <= '0;
        end else if (r_acc_s || r_acc_l) begin
            if (r_acc_s) begin
                r_short_sum <= r_short_sum + SUM_W'(r_rdata);
            end
            if (r_acc_l) begin
                r_long_sum <= r_long_sum + SUM_W'(r_rdata);
            end
        end else if (commit && !r_oo && bucket_inc) begin
            r_short_sum <= r_short_sum + SUM_W'(1);
            r_long_sum  <= r_long_sum + SUM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_total <= '0;
            r_out_valid  <= 1'b0;
        end else if (commit) begin
            r_drop_total <= drop_next;
            r_out_valid  <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_data <= {PAD_W'(0), drop_next, r_oo, drop};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_ring_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ring_wr && ring_rd))
        else $error("ring written and read in the same cycle");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cur_idx} < DEPTH_A)
        else $error("current ring index beyond ring depth");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swrl_pkg::S_WALK) |-> (r_k < r_walk_n))
        else $error("ring walk ran past its length");

    a_commit_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swrl_pkg::S_UPD && r_out_valid && !m_axis_tready)
            |=> (r_state == swrl_pkg::S_UPD))
        else $error("update left while the output register was full");

endmodule
